// ===== src/hslc_pkg.sv =====
`default_nettype none

package hslc_pkg;

   // field widths
   localparam int unsigned CH_W        = 8;
   localparam int unsigned HUE_W       = 9;
   localparam int unsigned SAT_W       = 10;
   localparam int unsigned SUM_W       = 9;
   localparam int unsigned LIMIT_W     = 10;
   localparam int unsigned CSR_INDEX_W = 4;

   // divider operand widths
   localparam int unsigned DIV_DEN_W   = 8;
   localparam int unsigned HUE_NUM_W   = DIV_DEN_W + HUE_W;
   localparam int unsigned SAT_NUM_W   = DIV_DEN_W + SAT_W;

   // exact comparison product widths
   localparam int unsigned LIGHT_PROD_W = 19;
   localparam int unsigned SAT_PROD_W   = 18;

   // scale factors: lightness sum is lightness times 510, limits are thousandths
   localparam int unsigned MILLI_SCALE          = 1000;
   localparam int unsigned SUM_SCALE            = 510;
   localparam int unsigned RED_LIGHT_MIN_MILLI  = 320;
   localparam int unsigned BLUE_LIGHT_MIN_MILLI = 220;

   typedef enum logic [1:0] {
      CLASS_OTHER = 2'd0,
      CLASS_RED   = 2'd1,
      CLASS_BLUE  = 2'd2,
      CLASS_WHITE = 2'd3
   } class_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RED_HUE_BELOW      = 4'd0,
      CSR_RED_HUE_ABOVE      = 4'd1,
      CSR_BLUE_HUE_MIN       = 4'd2,
      CSR_BLUE_HUE_MAX       = 4'd3,
      CSR_BRIGHT_LIGHT_LIMIT = 4'd4,
      CSR_PALE_LIGHT_LIMIT   = 4'd5,
      CSR_PALE_SAT_LIMIT     = 4'd6,
      CSR_RED_SAT_MIN        = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [HUE_W-1:0]   red_hue_below;
      logic [HUE_W-1:0]   red_hue_above;
      logic [HUE_W-1:0]   blue_hue_min;
      logic [HUE_W-1:0]   blue_hue_max;
      logic [LIMIT_W-1:0] bright_light_limit;
      logic [LIMIT_W-1:0] pale_light_limit;
      logic [LIMIT_W-1:0] pale_sat_limit;
      logic [LIMIT_W-1:0] red_sat_min;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      red_hue_below:      9'd15,
      red_hue_above:      9'd315,
      blue_hue_min:       9'd180,
      blue_hue_max:       9'd245,
      bright_light_limit: 10'd790,
      pale_light_limit:   10'd720,
      pale_sat_limit:     10'd350,
      red_sat_min:        10'd430
   };

   // threshold results that do not depend on hue
   typedef struct packed {
      logic red_sat;       // saturation above red minimum
      logic blue_sat;      // saturation above pale limit
      logic pale_sat;      // saturation below pale limit
      logic red_light;     // lightness above red minimum
      logic blue_light;    // lightness above blue minimum
      logic below_bright;  // lightness below bright limit
      logic pale_light;    // lightness above pale limit
   } flags_type;

   // sideband carried through the hue divider
   typedef struct packed {
      logic [SAT_NUM_W-1:0] sat_num;
      logic [DIV_DEN_W-1:0] sat_den;
      logic [SUM_W-1:0]     sum;
      flags_type            flags;
   } hue_side_type;

   // sideband carried through the saturation divider
   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [SUM_W-1:0] sum;
      flags_type        flags;
   } sat_side_type;

endpackage

`default_nettype wire

// ===== src/hslc_front.sv =====
`default_nettype none

module hslc_front (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               in_valid,
   output logic                              in_ready,
   input  wire  [hslc_pkg::CH_W-1:0]         red,
   input  wire  [hslc_pkg::CH_W-1:0]         green,
   input  wire  [hslc_pkg::CH_W-1:0]         blue,
   input  hslc_pkg::cfg_type                 cfg,
   output logic                              out_valid,
   input  wire                               out_ready,
   output logic [hslc_pkg::HUE_NUM_W-1:0]    hue_num,
   output logic [hslc_pkg::DIV_DEN_W-1:0]    hue_den,
   output hslc_pkg::hue_side_type            side
);
   import hslc_pkg::*;

   typedef enum logic [1:0] {
      SEC_RED   = 2'd0,
      SEC_GREEN = 2'd1,
      SEC_BLUE  = 2'd2
   } sector_type;

   localparam logic [LIGHT_PROD_W-1:0] RED_LIGHT_PROD =
      LIGHT_PROD_W'(SUM_SCALE * RED_LIGHT_MIN_MILLI);
   localparam logic [LIGHT_PROD_W-1:0] BLUE_LIGHT_PROD =
      LIGHT_PROD_W'(SUM_SCALE * BLUE_LIGHT_MIN_MILLI);
   localparam logic [SUM_W-1:0] SUM_MID  = SUM_W'(255);
   localparam logic [SUM_W-1:0] SUM_FULL = SUM_W'(510);

   logic [2:0] v_ff;
   logic [3:0] rdy;

   // stage A registers
   logic [SUM_W-1:0] sum_a_ff,   sum_a_in;
   logic [CH_W-1:0]  delta_a_ff, delta_a_in;
   logic [CH_W-1:0]  diff_a_ff,  diff_a_in;
   logic             neg_a_ff,   neg_a_in;
   sector_type       sec_a_ff,   sec_a_in;

   // stage B registers
   logic [HUE_NUM_W-1:0] hue_num_b_ff, hue_num_b_in;
   logic [DIV_DEN_W-1:0] hue_den_b_ff, hue_den_b_in;
   logic [SAT_NUM_W-1:0] sat_num_b_ff, sat_num_b_in;
   logic [DIV_DEN_W-1:0] sat_den_b_ff, sat_den_b_in;
   logic [SUM_W-1:0]     sum_b_ff;

   // stage C registers
   logic [HUE_NUM_W-1:0] hue_num_c_ff;
   logic [DIV_DEN_W-1:0] hue_den_c_ff;
   hue_side_type         side_c_ff, side_c_in;

   // stage A: max, min, sector and channel difference
   always_comb begin
      logic [CH_W-1:0] mx;
      logic [CH_W-1:0] mn;
      logic [CH_W-1:0] ca;
      logic [CH_W-1:0] cb;
      mx = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      mn = red;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      if (red == mx) begin
         sec_a_in = SEC_RED;
         ca = green;
         cb = blue;
      end else if (green == mx) begin
         sec_a_in = SEC_GREEN;
         ca = blue;
         cb = red;
      end else begin
         sec_a_in = SEC_BLUE;
         ca = red;
         cb = green;
      end
      neg_a_in   = (ca < cb);
      diff_a_in  = neg_a_in ? (cb - ca) : (ca - cb);
      sum_a_in   = {1'b0, mx} + {1'b0, mn};
      delta_a_in = mx - mn;
   end

   // stage B: hue numerator and saturation fraction
   always_comb begin
      logic                 gray;
      logic [HUE_W-1:0]     base;
      logic [HUE_NUM_W-1:0] base_prod;
      logic [HUE_NUM_W-1:0] step;
      gray = (delta_a_ff == '0);
      unique case (sec_a_ff)
         SEC_RED:   base = neg_a_ff ? HUE_W'(360) : HUE_W'(0);
         SEC_GREEN: base = HUE_W'(120);
         SEC_BLUE:  base = HUE_W'(240);
         default:   base = HUE_W'(0);
      endcase
      base_prod = HUE_NUM_W'(base) * HUE_NUM_W'(delta_a_ff);
      step      = HUE_NUM_W'(diff_a_ff) * HUE_NUM_W'(60);
      if (gray) begin
         hue_num_b_in = '0;
         hue_den_b_in = DIV_DEN_W'(1);
         sat_den_b_in = DIV_DEN_W'(1);
      end else begin
         hue_num_b_in = neg_a_ff ? (base_prod - step) : (base_prod + step);
         hue_den_b_in = delta_a_ff;
         sat_den_b_in = (sum_a_ff <= SUM_MID) ? sum_a_ff[DIV_DEN_W-1:0]
                                              : DIV_DEN_W'(SUM_FULL - sum_a_ff);
      end
      sat_num_b_in = SAT_NUM_W'(delta_a_ff) * SAT_NUM_W'(MILLI_SCALE);
   end

   // stage C: exact threshold compares in thousandths
   always_comb begin
      logic [LIGHT_PROD_W-1:0] light;
      logic [LIGHT_PROD_W-1:0] bright_prod;
      logic [LIGHT_PROD_W-1:0] pale_light_prod;
      logic [SAT_PROD_W-1:0]   red_sat_prod;
      logic [SAT_PROD_W-1:0]   pale_sat_prod;
      light           = LIGHT_PROD_W'(sum_b_ff) * LIGHT_PROD_W'(MILLI_SCALE);
      bright_prod     = LIGHT_PROD_W'(cfg.bright_light_limit) * LIGHT_PROD_W'(SUM_SCALE);
      pale_light_prod = LIGHT_PROD_W'(cfg.pale_light_limit) * LIGHT_PROD_W'(SUM_SCALE);
      red_sat_prod    = SAT_PROD_W'(cfg.red_sat_min) * SAT_PROD_W'(sat_den_b_ff);
      pale_sat_prod   = SAT_PROD_W'(cfg.pale_sat_limit) * SAT_PROD_W'(sat_den_b_ff);
      side_c_in.sat_num            = sat_num_b_ff;
      side_c_in.sat_den            = sat_den_b_ff;
      side_c_in.sum                = sum_b_ff;
      side_c_in.flags.red_sat      = (sat_num_b_ff > red_sat_prod);
      side_c_in.flags.blue_sat     = (sat_num_b_ff > pale_sat_prod);
      side_c_in.flags.pale_sat     = (sat_num_b_ff < pale_sat_prod);
      side_c_in.flags.red_light    = (light > RED_LIGHT_PROD);
      side_c_in.flags.blue_light   = (light > BLUE_LIGHT_PROD);
      side_c_in.flags.below_bright = (light < bright_prod);
      side_c_in.flags.pale_light   = (light > pale_light_prod);
   end

   // advance a stage when it is empty or the next one moves
   always_comb begin
      rdy[3] = out_ready;
      rdy[2] = !v_ff[2] || rdy[3];
      rdy[1] = !v_ff[1] || rdy[2];
      rdy[0] = !v_ff[0] || rdy[1];
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[2];
   assign hue_num   = hue_num_c_ff;
   assign hue_den   = hue_den_c_ff;
   assign side      = side_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         if (rdy[1]) v_ff[1] <= v_ff[0];
         if (rdy[2]) v_ff[2] <= v_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         sum_a_ff   <= sum_a_in;
         delta_a_ff <= delta_a_in;
         diff_a_ff  <= diff_a_in;
         neg_a_ff   <= neg_a_in;
         sec_a_ff   <= sec_a_in;
      end
      if (rdy[1]) begin
         hue_num_b_ff <= hue_num_b_in;
         hue_den_b_ff <= hue_den_b_in;
         sat_num_b_ff <= sat_num_b_in;
         sat_den_b_ff <= sat_den_b_in;
         sum_b_ff     <= sum_a_ff;
      end
      if (rdy[2]) begin
         hue_num_c_ff <= hue_num_b_ff;
         hue_den_c_ff <= hue_den_b_ff;
         side_c_ff    <= side_c_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/hslc_divider.sv =====
`default_nettype none

module hslc_divider #(
   parameter int unsigned DEN_W  = 8,
   parameter int unsigned QUO_W  = 9,
   parameter int unsigned SIDE_W = 1
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      in_valid,
   output logic                     in_ready,
   input  wire  [DEN_W+QUO_W-1:0]   num,
   input  wire  [DEN_W-1:0]         den,
   input  wire  [SIDE_W-1:0]        side,
   output logic                     out_valid,
   input  wire                      out_ready,
   output logic [QUO_W-1:0]         quo,
   output logic [SIDE_W-1:0]        out_side
);
   // one restoring step per stage, quotient MSB first;
   // the caller keeps num below den times 2**QUO_W
   localparam int unsigned NUM_W = DEN_W + QUO_W;

   logic [QUO_W-1:0]  v_ff;
   logic [QUO_W:0]    rdy;

   logic [NUM_W-1:0]  rem_ff  [QUO_W];
   logic [NUM_W-1:0]  rem_in  [QUO_W];
   logic [NUM_W-1:0]  rem_src [QUO_W];
   logic [DEN_W-1:0]  den_ff  [QUO_W];
   logic [DEN_W-1:0]  den_in  [QUO_W];
   logic [QUO_W-1:0]  quo_ff  [QUO_W];
   logic [QUO_W-1:0]  quo_in  [QUO_W];
   logic [QUO_W-1:0]  quo_src [QUO_W];
   logic [SIDE_W-1:0] side_ff [QUO_W];
   logic [SIDE_W-1:0] side_in [QUO_W];

   // compare and subtract the shifted divisor in each stage
   always_comb begin
      logic [NUM_W-1:0] trial;
      rem_src[0] = num;
      quo_src[0] = '0;
      den_in[0]  = den;
      side_in[0] = side;
      for (int i = 1; i < QUO_W; i++) begin
         rem_src[i] = rem_ff[i-1];
         quo_src[i] = quo_ff[i-1];
         den_in[i]  = den_ff[i-1];
         side_in[i] = side_ff[i-1];
      end
      for (int i = 0; i < QUO_W; i++) begin
         trial = NUM_W'(den_in[i]) << (QUO_W - 1 - i);
         quo_in[i] = quo_src[i];
         if (rem_src[i] >= trial) begin
            rem_in[i] = rem_src[i] - trial;
            quo_in[i][QUO_W-1-i] = 1'b1;
         end else begin
            rem_in[i] = rem_src[i];
         end
      end
   end

   // advance a stage when it is empty or the next one moves
   always_comb begin
      rdy[QUO_W] = out_ready;
      for (int i = QUO_W - 1; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[QUO_W-1];
   assign quo       = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         for (int i = 1; i < QUO_W; i++) begin
            if (rdy[i]) v_ff[i] <= v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUO_W; i++) begin
         if (rdy[i]) begin
            rem_ff[i]  <= rem_in[i];
            den_ff[i]  <= den_in[i];
            quo_ff[i]  <= quo_in[i];
            side_ff[i] <= side_in[i];
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/hslc_classify.sv =====
`default_nettype none

module hslc_classify (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          in_valid,
   output logic                         in_ready,
   input  wire  [hslc_pkg::SAT_W-1:0]   sat,
   input  hslc_pkg::sat_side_type       side,
   input  hslc_pkg::cfg_type            cfg,
   output logic                         out_valid,
   input  wire                          out_ready,
   output hslc_pkg::class_type          class_code,
   output logic [hslc_pkg::HUE_W-1:0]   hue_degrees,
   output logic [hslc_pkg::SAT_W-1:0]   saturation_milli,
   output logic [hslc_pkg::SUM_W-1:0]   lightness_sum
);
   import hslc_pkg::*;

   logic             out_valid_ff;
   class_type        class_ff, class_in;
   logic [HUE_W-1:0] hue_ff;
   logic [SAT_W-1:0] sat_ff;
   logic [SUM_W-1:0] sum_ff;

   // pick the class in priority order: red, blue, white
   always_comb begin
      logic is_red;
      logic is_blue;
      logic is_white;
      is_red   = (side.hue < cfg.red_hue_below || side.hue > cfg.red_hue_above)
                 && side.flags.red_sat && side.flags.red_light
                 && side.flags.below_bright;
      is_blue  = (side.hue < cfg.blue_hue_max) && (side.hue > cfg.blue_hue_min)
                 && side.flags.blue_sat && side.flags.below_bright
                 && side.flags.blue_light;
      is_white = !side.flags.below_bright
                 || (side.flags.pale_light && side.flags.pale_sat);
      priority if (is_red)   class_in = CLASS_RED;
      else if (is_blue)      class_in = CLASS_BLUE;
      else if (is_white)     class_in = CLASS_WHITE;
      else                   class_in = CLASS_OTHER;
   end

   // hold the result until it is taken
   assign in_ready = !out_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (in_ready) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         class_ff <= class_in;
         hue_ff   <= side.hue;
         sat_ff   <= sat;
         sum_ff   <= side.sum;
      end
   end

   assign out_valid        = out_valid_ff;
   assign class_code       = class_ff;
   assign hue_degrees      = hue_ff;
   assign saturation_milli = sat_ff;
   assign lightness_sum    = sum_ff;

endmodule

`default_nettype wire

// ===== src/hsl_pixel_color_classifier_core.sv =====
`default_nettype none

// HSL pixel color classifier. Takes one 8-bit RGB pixel per request and
// returns its hue in whole degrees, its HSL saturation in thousandths, its
// lightness as max+min, and a class code (other, red, blue, white, with red
// taking priority over blue and blue over white). A new pixel is accepted in
// every clock cycle unless stalled; each pixel passes three front stages
// (max/min, hue and saturation fractions, threshold compares), a nine-stage
// hue divider, a ten-stage saturation divider and the output register. Stages
// that hold no pixel keep moving while the output is stalled, so bubbles close
// up before requests are held off. The user must write thresholds through the
// csr port only while no pixel is in flight; the block does not enforce it.
// Indexes past the last register are ignored, unused high data bits dropped.
module hsl_pixel_color_classifier_core (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire  [hslc_pkg::CH_W-1:0]          req_red,
   input  wire  [hslc_pkg::CH_W-1:0]          req_green,
   input  wire  [hslc_pkg::CH_W-1:0]          req_blue,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic [1:0]                         rsp_class_code,
   output logic [hslc_pkg::HUE_W-1:0]         rsp_hue_degrees,
   output logic [hslc_pkg::SAT_W-1:0]         rsp_saturation_milli,
   output logic [hslc_pkg::SUM_W-1:0]         rsp_lightness_sum,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [hslc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [hslc_pkg::LIMIT_W-1:0]       csr_wdata
);
   import hslc_pkg::*;

   cfg_type cfg_ff;

   logic                 front_ready;
   logic                 front_valid;
   logic [HUE_NUM_W-1:0] front_hue_num;
   logic [DIV_DEN_W-1:0] front_hue_den;
   hue_side_type         front_side;

   logic                 hue_ready;
   logic                 hue_valid;
   logic [HUE_W-1:0]     hue_quo;
   hue_side_type         hue_side;
   logic [$bits(hue_side_type)-1:0] hue_side_bits;

   logic                 sat_ready;
   logic                 sat_valid;
   logic [SAT_W-1:0]     sat_quo;
   sat_side_type         sat_side_next;
   logic [$bits(sat_side_type)-1:0] sat_side_bits;

   logic                 out_ready;
   class_type            class_code;

   // register writes, always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_RED_HUE_BELOW:      cfg_ff.red_hue_below      <= csr_wdata[HUE_W-1:0];
            CSR_RED_HUE_ABOVE:      cfg_ff.red_hue_above      <= csr_wdata[HUE_W-1:0];
            CSR_BLUE_HUE_MIN:       cfg_ff.blue_hue_min       <= csr_wdata[HUE_W-1:0];
            CSR_BLUE_HUE_MAX:       cfg_ff.blue_hue_max       <= csr_wdata[HUE_W-1:0];
            CSR_BRIGHT_LIGHT_LIMIT: cfg_ff.bright_light_limit <= csr_wdata;
            CSR_PALE_LIGHT_LIMIT:   cfg_ff.pale_light_limit   <= csr_wdata;
            CSR_PALE_SAT_LIMIT:     cfg_ff.pale_sat_limit     <= csr_wdata;
            CSR_RED_SAT_MIN:        cfg_ff.red_sat_min        <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_stall = !front_ready;

   hslc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .cfg       (cfg_ff),
      .out_valid (front_valid),
      .out_ready (hue_ready),
      .hue_num   (front_hue_num),
      .hue_den   (front_hue_den),
      .side      (front_side)
   );

   hslc_divider #(
      .DEN_W  (DIV_DEN_W),
      .QUO_W  (HUE_W),
      .SIDE_W ($bits(hue_side_type))
   ) u_hue_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (hue_ready),
      .num       (front_hue_num),
      .den       (front_hue_den),
      .side      (front_side),
      .out_valid (hue_valid),
      .out_ready (sat_ready),
      .quo       (hue_quo),
      .out_side  (hue_side_bits)
   );

   // hand hue forward with the saturation fraction
   assign hue_side            = hue_side_type'(hue_side_bits);
   assign sat_side_next.hue   = hue_quo;
   assign sat_side_next.sum   = hue_side.sum;
   assign sat_side_next.flags = hue_side.flags;

   hslc_divider #(
      .DEN_W  (DIV_DEN_W),
      .QUO_W  (SAT_W),
      .SIDE_W ($bits(sat_side_type))
   ) u_sat_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (hue_valid),
      .in_ready  (sat_ready),
      .num       (hue_side.sat_num),
      .den       (hue_side.sat_den),
      .side      (sat_side_next),
      .out_valid (sat_valid),
      .out_ready (out_ready),
      .quo       (sat_quo),
      .out_side  (sat_side_bits)
   );

   hslc_classify u_classify (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (sat_valid),
      .in_ready         (out_ready),
      .sat              (sat_quo),
      .side             (sat_side_type'(sat_side_bits)),
      .cfg              (cfg_ff),
      .out_valid        (rsp_valid),
      .out_ready        (!rsp_stall),
      .class_code       (class_code),
      .hue_degrees      (rsp_hue_degrees),
      .saturation_milli (rsp_saturation_milli),
      .lightness_sum    (rsp_lightness_sum)
   );

   assign rsp_class_code = class_code;

endmodule

`default_nettype wire

// ===== tb/hslc_checker.sv =====
`default_nettype none

// Watches the pixel, result and csr channels of the classifier, predicts each
// result from its own copy of the thresholds and compares in arrival order.
module hslc_checker
   import hslc_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   input  wire                      req_stall,
   input  wire  [CH_W-1:0]          req_red,
   input  wire  [CH_W-1:0]          req_green,
   input  wire  [CH_W-1:0]          req_blue,
   input  wire                      rsp_valid,
   input  wire                      rsp_stall,
   input  wire  [1:0]               rsp_class_code,
   input  wire  [HUE_W-1:0]         rsp_hue_degrees,
   input  wire  [SAT_W-1:0]         rsp_saturation_milli,
   input  wire  [SUM_W-1:0]         rsp_lightness_sum,
   input  wire                      csr_valid,
   input  wire                      csr_ready,
   input  wire  [CSR_INDEX_W-1:0]   csr_index,
   input  wire  [LIMIT_W-1:0]       csr_wdata,
   output int unsigned              fail_count,
   output int unsigned              open_count
);

   typedef struct packed {
      logic [CH_W-1:0]  red;
      logic [CH_W-1:0]  green;
      logic [CH_W-1:0]  blue;
      class_type        cls;
      logic [HUE_W-1:0] hue;
      logic [SAT_W-1:0] sat;
      logic [SUM_W-1:0] sum;
   } pixel_result_type;

   cfg_type          thresholds;
   pixel_result_type pending_results [$];
   int unsigned      mismatch_total;

   initial begin
      fail_count     = 0;
      open_count     = 0;
      mismatch_total = 0;
      thresholds     = CFG_RESET;
   end

   // max+min lightness sum against a limit in thousandths: -1, 0 or 1
   function automatic int cmp_lightness(input int unsigned sum, input int unsigned milli);
      int unsigned lhs;
      int unsigned rhs;
      lhs = MILLI_SCALE * sum;
      rhs = SUM_SCALE * milli;
      return (lhs > rhs) ? 1 : ((lhs < rhs) ? -1 : 0);
   endfunction

   // saturation fraction num/den against a limit in thousandths
   function automatic int cmp_saturation(input int unsigned num, input int unsigned den,
                                         input int unsigned milli);
      int unsigned lhs;
      int unsigned rhs;
      lhs = MILLI_SCALE * num;
      rhs = milli * den;
      return (lhs > rhs) ? 1 : ((lhs < rhs) ? -1 : 0);
   endfunction

   // convert one pixel to HSL and classify it against the current thresholds
   function automatic pixel_result_type classify_pixel(input logic [CH_W-1:0] r8,
                                                       input logic [CH_W-1:0] g8,
                                                       input logic [CH_W-1:0] b8);
      int unsigned      r, g, b, mx, mn, sum, delta;
      int unsigned      hue, snum, sden;
      logic             red_hit, blue_hit, white_hit;
      pixel_result_type res;
      r = r8;
      g = g8;
      b = b8;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      sum   = mx + mn;
      delta = mx - mn;
      hue   = 0;
      snum  = 0;
      sden  = 1;

      // gray leaves hue and saturation at zero; ties pick red, then green
      if (delta != 0) begin
         snum = delta;
         sden = (sum <= 255) ? sum : (510 - sum);
         if (r == mx) begin
            if (g >= b) hue = (60 * (g - b)) / delta;
            else hue = (360 * delta - 60 * (b - g)) / delta;
         end else if (g == mx) begin
            if (b >= r) hue = (120 * delta + 60 * (b - r)) / delta;
            else hue = (120 * delta - 60 * (r - b)) / delta;
         end else begin
            if (r >= g) hue = (240 * delta + 60 * (r - g)) / delta;
            else hue = (240 * delta - 60 * (g - r)) / delta;
         end
      end

      red_hit = (hue < thresholds.red_hue_below || hue > thresholds.red_hue_above)
             && cmp_saturation(snum, sden, thresholds.red_sat_min) > 0
             && cmp_lightness(sum, RED_LIGHT_MIN_MILLI) > 0
             && cmp_lightness(sum, thresholds.bright_light_limit) < 0;
      blue_hit = hue < thresholds.blue_hue_max && hue > thresholds.blue_hue_min
              && cmp_saturation(snum, sden, thresholds.pale_sat_limit) > 0
              && cmp_lightness(sum, thresholds.bright_light_limit) < 0
              && cmp_lightness(sum, BLUE_LIGHT_MIN_MILLI) > 0;
      white_hit = cmp_lightness(sum, thresholds.bright_light_limit) >= 0
               || (cmp_lightness(sum, thresholds.pale_light_limit) > 0
                   && cmp_saturation(snum, sden, thresholds.pale_sat_limit) < 0);

      res.red   = r8;
      res.green = g8;
      res.blue  = b8;
      if (red_hit) res.cls = CLASS_RED;
      else if (blue_hit) res.cls = CLASS_BLUE;
      else if (white_hit) res.cls = CLASS_WHITE;
      else res.cls = CLASS_OTHER;
      res.hue = hue[HUE_W-1:0];
      res.sat = SAT_W'((MILLI_SCALE * snum) / sden);
      res.sum = sum[SUM_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         thresholds = CFG_RESET;
         pending_results.delete();
      end else begin
         // track threshold writes; unused high bits drop, unknown indexes do nothing
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_RED_HUE_BELOW:      thresholds.red_hue_below      = csr_wdata[HUE_W-1:0];
               CSR_RED_HUE_ABOVE:      thresholds.red_hue_above      = csr_wdata[HUE_W-1:0];
               CSR_BLUE_HUE_MIN:       thresholds.blue_hue_min       = csr_wdata[HUE_W-1:0];
               CSR_BLUE_HUE_MAX:       thresholds.blue_hue_max       = csr_wdata[HUE_W-1:0];
               CSR_BRIGHT_LIGHT_LIMIT: thresholds.bright_light_limit = csr_wdata;
               CSR_PALE_LIGHT_LIMIT:   thresholds.pale_light_limit   = csr_wdata;
               CSR_PALE_SAT_LIMIT:     thresholds.pale_sat_limit     = csr_wdata;
               CSR_RED_SAT_MIN:        thresholds.red_sat_min        = csr_wdata;
               default: ;
            endcase
         end

         // predict each accepted pixel request
         if (req_valid && !req_stall)
            pending_results = {pending_results,
                               classify_pixel(req_red, req_green, req_blue)};

         // compare each accepted result with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10)
                  $display("unexpected result: class %0d hue %0d sat %0d sum %0d",
                           rsp_class_code, rsp_hue_degrees, rsp_saturation_milli,
                           rsp_lightness_sum);
            end else begin
               want = pending_results.pop_front();
               if (want.cls != rsp_class_code || want.hue != rsp_hue_degrees
                   || want.sat != rsp_saturation_milli || want.sum != rsp_lightness_sum) begin
                  mismatch_total++;
                  if (mismatch_total <= 10) begin
                     $write("mismatch on pixel (%0d,%0d,%0d): expected class %0d hue %0d",
                            want.red, want.green, want.blue, want.cls, want.hue);
                     $display(" sat %0d sum %0d, got class %0d hue %0d sat %0d sum %0d",
                              want.sat, want.sum, rsp_class_code, rsp_hue_degrees,
                              rsp_saturation_milli, rsp_lightness_sum);
                  end
               end
            end
         end
      end
      fail_count <= mismatch_total;
      open_count <= pending_results.size();
   end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
   import hslc_pkg::*;

   localparam int unsigned IDLE_LIMIT   = 2000;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned RANDOM_FIRST = 75;
   localparam int unsigned RANDOM_PHASE = 55;
   localparam csr_index_type CSR_INDEX_LAST = CSR_RED_SAT_MIN;

   typedef enum int {
      CFG_ZERO,
      CFG_TOP,
      CFG_ALL_ONES,
      CFG_RANDOM,
      CFG_DEFAULT
   } cfg_style_type;

   typedef enum int {
      PIX_UNIFORM,
      PIX_NEAR_GRAY,
      PIX_TIE,
      PIX_EXTREME,
      PIX_DOMINANT,
      PIX_PALE
   } pixel_style_type;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_style_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [CH_W-1:0]        req_red   = '0;
   logic [CH_W-1:0]        req_green = '0;
   logic [CH_W-1:0]        req_blue  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [1:0]             rsp_class_code;
   logic [HUE_W-1:0]       rsp_hue_degrees;
   logic [SAT_W-1:0]       rsp_saturation_milli;
   logic [SUM_W-1:0]       rsp_lightness_sum;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [LIMIT_W-1:0]     csr_wdata = '0;
   int unsigned            fail_count;
   int unsigned            open_count;

   int unsigned            burst_left = 0;
   int unsigned            idle_cycles = 0;
   stall_style_type        stall_style = STALL_NONE;
   int unsigned            stall_span = 0;

   // black, white, gray, primaries, max-channel ties, every hue sector branch,
   // red-sector wrap below zero, near-gray and one-step pixels
   logic [23:0] corner_pixels [25] = '{
      24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00,
      24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF000A,
      24'h0AFF00, 24'h00FF64, 24'h6400FF, 24'h0064FF, 24'hF0E6EB,
      24'h00003C, 24'hFF6464, 24'hC81E1E, 24'h010000, 24'hFFFEFE,
      24'h000001, 24'hFEFFFF, 24'h800000, 24'h3C50C8, 24'h010100
   };

   cfg_style_type phase_plan [8] = '{
      CFG_ZERO, CFG_TOP, CFG_ALL_ONES, CFG_RANDOM,
      CFG_RANDOM, CFG_RANDOM, CFG_RANDOM, CFG_DEFAULT
   };

   hsl_pixel_color_classifier_core DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_red              (req_red),
      .req_green            (req_green),
      .req_blue             (req_blue),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_class_code       (rsp_class_code),
      .rsp_hue_degrees      (rsp_hue_degrees),
      .rsp_saturation_milli (rsp_saturation_milli),
      .rsp_lightness_sum    (rsp_lightness_sum),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   hslc_checker checker_i (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_red              (req_red),
      .req_green            (req_green),
      .req_blue             (req_blue),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_class_code       (rsp_class_code),
      .rsp_hue_degrees      (rsp_hue_degrees),
      .rsp_saturation_milli (rsp_saturation_milli),
      .rsp_lightness_sum    (rsp_lightness_sum),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .fail_count           (fail_count),
      .open_count           (open_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // pick a new result stall pattern whenever the current random span runs out
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_style <= stall_style_type'($urandom_range(STALL_NONE, STALL_PERIODIC));
         stall_span  <= $urandom_range(40, 200);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_style)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
         STALL_PERIODIC: rsp_stall <= ((stall_span % 8) < 5);
         default:        rsp_stall <= 1'b0;
      endcase
   end

   // end the run when no channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // random pixel, weighted toward grays, ties, extremes and strong colors
   function automatic logic [23:0] pick_pixel();
      int unsigned     pick;
      pixel_style_type style;
      logic [CH_W-1:0] r, g, b, base;
      pick  = $urandom_range(0, 7);
      style = (pick > PIX_PALE) ? PIX_UNIFORM : pixel_style_type'(pick);
      r     = CH_W'($urandom);
      g     = CH_W'($urandom);
      b     = CH_W'($urandom);
      base  = CH_W'($urandom);
      case (style)
         PIX_NEAR_GRAY: begin
            r = base ^ CH_W'($urandom_range(0, 3));
            g = base ^ CH_W'($urandom_range(0, 3));
            b = base ^ CH_W'($urandom_range(0, 3));
         end
         PIX_TIE: begin
            case ($urandom_range(0, 2))
               0: g = r;
               1: b = g;
               default: b = r;
            endcase
         end
         PIX_EXTREME: begin
            if ($urandom_range(0, 2) != 0) r = {CH_W{r[0]}};
            if ($urandom_range(0, 2) != 0) g = {CH_W{g[0]}};
            if ($urandom_range(0, 2) != 0) b = {CH_W{b[0]}};
         end
         PIX_DOMINANT: begin
            r = r >> 2;
            g = g >> 2;
            b = b >> 2;
            case ($urandom_range(0, 2))
               0: r = base | 8'h80;
               1: g = base | 8'h80;
               default: b = base | 8'h80;
            endcase
         end
         PIX_PALE: begin
            r = r | 8'hB0;
            g = g | 8'hB0;
            b = b | 8'hB0;
         end
         default: ;
      endcase
      return {r, g, b};
   endfunction

   // hand one pixel request over, opening a random gap between bursts
   task automatic send_pixel(input logic [23:0] pixel);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_red   <= pixel[23:16];
      req_green <= pixel[15:8];
      req_blue  <= pixel[7:0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // hold one register write until the block takes it
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [LIMIT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // stop sending and wait until every result is back
   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
   endtask

   // write all eight thresholds in one style, then one write to an unused index
   task automatic program_thresholds(input cfg_style_type style);
      logic [LIMIT_W-1:0] value;
      int unsigned        top;
      logic               hue_reg;
      for (int i = 0; i <= int'(CSR_INDEX_LAST); i++) begin
         hue_reg = (i <= int'(CSR_BLUE_HUE_MAX));
         top     = hue_reg ? 360 : 1000;
         case (style)
            CFG_ZERO:     value = '0;
            CFG_TOP:      value = LIMIT_W'(top);
            CFG_ALL_ONES: value = '1;
            CFG_RANDOM: begin
               if ($urandom_range(0, 7) == 0) value = LIMIT_W'($urandom);
               else value = LIMIT_W'($urandom_range(0, top));
               // a set bit above a hue register's width must be dropped
               if (hue_reg && $urandom_range(0, 3) == 0) value[LIMIT_W-1] = 1'b1;
            end
            default: begin
               case (csr_index_type'(i))
                  CSR_RED_HUE_BELOW:      value = LIMIT_W'(CFG_RESET.red_hue_below);
                  CSR_RED_HUE_ABOVE:      value = LIMIT_W'(CFG_RESET.red_hue_above);
                  CSR_BLUE_HUE_MIN:       value = LIMIT_W'(CFG_RESET.blue_hue_min);
                  CSR_BLUE_HUE_MAX:       value = LIMIT_W'(CFG_RESET.blue_hue_max);
                  CSR_BRIGHT_LIGHT_LIMIT: value = CFG_RESET.bright_light_limit;
                  CSR_PALE_LIGHT_LIMIT:   value = CFG_RESET.pale_light_limit;
                  CSR_PALE_SAT_LIMIT:     value = CFG_RESET.pale_sat_limit;
                  default:                value = CFG_RESET.red_sat_min;
               endcase
            end
         endcase
         csr_write(csr_index_type'(i), value);
      end
      csr_write(CSR_INDEX_W'(int'(CSR_INDEX_LAST) + 1 + $urandom_range(0, 7)),
                LIMIT_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset thresholds: corner pixels, then random ones
      foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
      repeat (RANDOM_FIRST) send_pixel(pick_pixel());

      // reprogram only once the pipeline is empty
      foreach (phase_plan[p]) begin
         drain_results();
         program_thresholds(phase_plan[p]);
         if (p == 0) foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
         repeat (RANDOM_PHASE) send_pixel(pick_pixel());
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && open_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
src/hslc_pkg.sv
src/hslc_front.sv
src/hslc_divider.sv
src/hslc_classify.sv
src/hsl_pixel_color_classifier_core.sv
tb/hslc_checker.sv
tb/testbench.sv
